// File: src/assert_macros.svh
// Assertion macros shared by the inversion counter RTL.
// Defining ASSERT_OFF compiles every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion, disabled while the active-low reset is asserted.
`define NSIC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define NSIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NSIC_ASSERT(lbl, clk, rstn, prop, msg)
`define NSIC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: src/nsic_pkg.sv
// Package for the non-strict inversion counter: sizes and the item token type.
// Used by nsic_cell, nsic_tail and non_strict_inversion_counter_top.
package nsic_pkg;

  localparam int unsigned MAX_ITEMS  = 1024;
  // Must not exceed the 16-bit width of the value port.
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_ITEMS);
  localparam int unsigned FILL_W     = IDX_W + 1;
  localparam int unsigned TOTAL_W    = 19;
  localparam int unsigned SUM_W      = ((IDX_W > TOTAL_W) ? IDX_W : TOTAL_W) + 1;

  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(MAX_ITEMS);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // One item travelling down the chain, with the count gathered so far.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic                  drop;
    logic [IDX_W-1:0]      idx;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      count;
  } nsic_tok_t;

endpackage

// File: src/non_strict_inversion_counter_top.sv
// Top level of the non-strict inversion counter: a chain of compare cells and a tail.
// Depends on nsic_pkg, nsic_cell, nsic_tail and assert_macros.svh.
//
// Usage: items arrive on the input channel (in_valid_i / in_ready_o) with a value and a
// last flag. Each value is compared against all earlier values of its sequence, and the
// number of earlier values greater than or equal to it is added to a running total.
// On the item marked last, one result (total, overflow) leaves on the output channel
// (out_valid_o / out_ready_i) and a new sequence starts with the next item.
// Items beyond MAX_ITEMS in a sequence are dropped and raise the overflow flag.
// Throughput is one item per cycle unless a pending result stalls the chain: each item
// walks down a row of MAX_ITEMS cells, one cell per cycle, and collects its count on the
// way while the item behind it follows one cell back. The last item's count
// passes each cell register of the row and then the result register. The fill count at
// the entry tells each item which cell it is stored in; no memory clearing is needed.
// After reset the block is empty and takes items at once. When the receiver stalls
// with a result pending, the whole chain holds and in_ready_o drops until the result
// is taken; no item is lost or repeated.
`include "assert_macros.svh"

module non_strict_inversion_counter_top
  import nsic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TOTAL_W-1:0] total_o,
  output logic               overflow_o
);

  nsic_tok_t         chain [MAX_ITEMS+1];
  logic              en;
  logic              accept;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              full;

  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign full       = (fill_q == FILL_FULL);

  // The fill count is the position of the next item; a full row drops the item.
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (last_i) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_comb begin
    chain[0].valid = accept;
    chain[0].last  = last_i;
    chain[0].drop  = full;
    chain[0].idx   = fill_q[IDX_W-1:0];
    chain[0].value = value_i[VALUE_BITS-1:0];
    chain[0].count = '0;
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    nsic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  nsic_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (chain[MAX_ITEMS]),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .total_o     (total_o),
    .overflow_o  (overflow_o)
  );

  `NSIC_ASSERT(a_fill_in_range, clk_i, rst_ni, fill_q <= FILL_FULL, "fill count beyond capacity")
  `NSIC_ASSERT(a_last_resets_fill, clk_i, rst_ni, accept && last_i |=> fill_q == '0, "fill count not reset by last item")
  `NSIC_ASSERT(a_full_holds, clk_i, rst_ni, accept && !last_i && full |=> full, "full row did not stay full")

endmodule

// File: src/nsic_cell.sv
// One cell of the comparison chain: holds one stored value and passes items on.
// Depends on nsic_pkg.
module nsic_cell
  import nsic_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  nsic_tok_t        tok_i,
  output nsic_tok_t        tok_o
);

  logic [VALUE_BITS-1:0] val_q;
  logic                  valid_q;
  nsic_tok_t             tok_q;
  logic                  live;
  logic                  hit;
  logic                  store;
  nsic_tok_t             tok_d;

  // Cells below the item's position hold earlier values of the sequence.
  always_comb begin
    live  = tok_i.valid && !tok_i.drop;
    hit   = live && (cell_idx_i < tok_i.idx) && (val_q >= tok_i.value);
    store = live && (cell_idx_i == tok_i.idx);
    tok_d = tok_i;
    tok_d.count = tok_i.count + IDX_W'(hit);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && store) begin
      val_q <= tok_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// File: src/nsic_tail.sv
// End of the chain: running total, overflow flag and the result register.
// Depends on nsic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nsic_tail
  import nsic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nsic_tok_t          tok_i,
  input  logic               out_ready_i,
  output logic               en_o,
  output logic               out_valid_o,
  output logic [TOTAL_W-1:0] total_o,
  output logic               overflow_o
);

  logic [TOTAL_W-1:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0] total_q;
  logic               overflow_q;
  logic               en;
  logic [SUM_W-1:0]   sum;
  logic [TOTAL_W-1:0] sat;
  logic               take;
  logic               emit;

  // The whole chain moves only when the result register can take a new result.
  assign en   = !out_valid_q || out_ready_i;
  assign take = en && tok_i.valid;
  assign emit = take && tok_i.last;

  always_comb begin
    sum = SUM_W'(acc_q) + (tok_i.drop ? SUM_W'(0) : SUM_W'(tok_i.count));
    sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    acc_d       = acc_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      acc_d = sat;
      ovf_d = ovf_q || tok_i.drop;
      if (tok_i.last) begin
        acc_d       = '0;
        ovf_d       = 1'b0;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      total_q    <= sat;
      overflow_q <= ovf_q || tok_i.drop;
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_valid_q;
  assign total_o     = total_q;
  assign overflow_o  = overflow_q;

  `NSIC_ASSERT(a_clear_after_last, clk_i, rst_ni, emit |=> (acc_q == '0) && !ovf_q, "state not cleared after last item")
  `NSIC_ASSERT(a_drop_sets_flag, clk_i, rst_ni, take && tok_i.drop && !tok_i.last |=> ovf_q, "dropped item did not set overflow")
  `NSIC_ASSERT(a_hold_on_stall, clk_i, rst_ni, !en |=> $stable(acc_q) && $stable(ovf_q), "running total moved while stalled")

endmodule
